// File: hdl/bad_pkg.sv
package bad_pkg;

    // Payload and register widths.
    localparam int TIME_W     = 32;
    localparam int PRESS_W    = 17;
    localparam int INTERVAL_W = 10;
    localparam int MARGIN_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // History ring geometry.
    localparam int HISTORY_DEPTH = 100;
    localparam int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);

    // Width of the window value plus margin, wide enough to never overflow.
    localparam int SUM_W = ((PRESS_W > MARGIN_W) ? PRESS_W : MARGIN_W) + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RISE_MARGIN     = CFG_IDX_W'(1);

    // Register values after reset.
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);
    localparam logic [MARGIN_W-1:0]   MARGIN_RESET   = MARGIN_W'(10);

    // Update request from the top level to the history ring.
    typedef struct packed {
        logic               fire;
        logic               sampled;
        logic [PRESS_W-1:0] pressure;
    } hist_upd_t;

endpackage

// File: hdl/bad_history.sv
module bad_history
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  bad_pkg::hist_upd_t             upd,
    input  logic [bad_pkg::MARGIN_W-1:0]   rise_margin,
    output logic                           apogee
);

    logic [bad_pkg::PRESS_W-1:0] mem [bad_pkg::HISTORY_DEPTH];
    logic [bad_pkg::PRESS_W-1:0] rd_data_reg;
    logic [bad_pkg::PTR_W-1:0]   ptr_reg;
    logic [bad_pkg::PTR_W-1:0]   ptr_next;
    logic [bad_pkg::PTR_W-1:0]   ptr_adv;
    logic                        full_reg;
    logic                        full_next;
    logic                        wr_en;
    logic [bad_pkg::SUM_W-1:0]   limit;

    // The window-old value plus margin; the new sample must exceed it.
    assign limit  = bad_pkg::SUM_W'(rd_data_reg) + bad_pkg::SUM_W'(rise_margin);
    assign apogee = upd.fire && upd.sampled && full_reg &&
                    (bad_pkg::SUM_W'(upd.pressure) > limit);

    // A sample is stored unless it flagged apogee.
    assign wr_en   = upd.fire && upd.sampled && !apogee;
    assign ptr_adv = (ptr_reg == bad_pkg::LAST_PTR) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        ptr_next  = ptr_reg;
        full_next = full_reg;
        if (wr_en)
        begin
            ptr_next = ptr_adv;
            if (ptr_reg == bad_pkg::LAST_PTR)
            begin
                full_next = 1'b1;
            end
        end
    end

    // Ring pointer and fill flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            full_reg <= full_next;
        end
    end

    // History memory. The read for an incoming transaction uses the pointer
    // as left by the transaction retiring in the same cycle, which never
    // equals the address being written then.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= upd.pressure;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_next];
        end
    end

endmodule

// File: hdl/barometric_apogee_detector.sv
// Barometric apogee detector.
// Input channel: in_valid, in_stall, time_ms, pressure. A transaction is taken
// at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, apogee, sampled. Every input
// transaction yields exactly one output transaction, in order.
// Configuration: cfg_valid, cfg_ready, cfg_index, cfg_data. cfg_ready is
// always high; index 0 sets sample_interval_ms, index 1 sets rise_margin,
// other indexes are ignored. Write only while the block is idle.
// Accepted transactions pass through the input register, then the result
// register. Throughput is one transaction per cycle while out_stall is low:
// the history memory is read on acceptance into the input register and the
// compare and ring update happen on the move into the result register.
// Reset (rst_n low, asynchronous) empties both stages, clears the last sample
// time, ring pointer and fill flag, and loads 10 into both registers. The
// history contents are not cleared; entries only affect apogee after the ring
// has been filled once.
// When out_stall holds a result, one more transaction is taken into the
// input register; after that in_stall rises until the result is taken.
module barometric_apogee_detector
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bad_pkg::TIME_W-1:0]        time_ms,
    input  logic [bad_pkg::PRESS_W-1:0]       pressure,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              apogee,
    output logic                              sampled,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bad_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [bad_pkg::INTERVAL_W-1:0] interval_reg;
    logic [bad_pkg::MARGIN_W-1:0]   margin_reg;
    logic [bad_pkg::TIME_W-1:0]     last_time_reg;
    logic                           s1_valid_reg;
    logic [bad_pkg::TIME_W-1:0]     s1_time_reg;
    logic [bad_pkg::PRESS_W-1:0]    s1_pressure_reg;
    logic                           out_valid_reg;
    logic                           apogee_reg;
    logic                           sampled_reg;
    logic                           in_accept;
    logic                           s1_fire;
    logic                           s1_sampled;
    logic                           hist_apogee;
    logic [bad_pkg::TIME_W-1:0]     elapsed;
    bad_pkg::hist_upd_t             upd;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= bad_pkg::INTERVAL_RESET;
            margin_reg   <= bad_pkg::MARGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bad_pkg::REG_SAMPLE_INTERVAL:
                begin
                    interval_reg <= cfg_data[bad_pkg::INTERVAL_W-1:0];
                end
                bad_pkg::REG_RISE_MARGIN:
                begin
                    margin_reg <= cfg_data[bad_pkg::MARGIN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: the input stage moves when the result register is free.
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    // Sampling decision with a wrapping time difference.
    assign elapsed    = s1_time_reg - last_time_reg;
    assign s1_sampled = elapsed >= bad_pkg::TIME_W'(interval_reg);

    assign upd.fire     = s1_fire;
    assign upd.sampled  = s1_sampled;
    assign upd.pressure = s1_pressure_reg;

    bad_history u_history
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (in_accept),
        .upd         (upd),
        .rise_margin (margin_reg),
        .apogee      (hist_apogee)
    );

    // Input stage control and last sample time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire && s1_sampled)
            begin
                last_time_reg <= s1_time_reg;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_time_reg     <= time_ms;
            s1_pressure_reg <= pressure;
        end
        if (s1_fire)
        begin
            apogee_reg  <= hist_apogee;
            sampled_reg <= s1_sampled;
        end
    end

    assign out_valid = out_valid_reg;
    assign apogee    = apogee_reg;
    assign sampled   = sampled_reg;

endmodule

// File: hdl/bad_checker.sv
module bad_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              apogee,
    input logic                              sampled,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);

    // Apogee is only ever flagged on an item that was taken as a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!apogee || sampled))
    else $error("apogee flagged on an item that was not sampled");

    // The input side only backs up while a result is held by the receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(apogee) && $stable(sampled)))
    else $error("held result changed");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind barometric_apogee_detector bad_checker u_bad_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .apogee    (apogee),
    .sampled   (sampled),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: tb/tb_barometric_apogee_detector.sv
module tb_barometric_apogee_detector;

    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 136;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRESS_MAX     = (1 << bad_pkg::PRESS_W) - 1;

    // Register indexes that the block must ignore.
    localparam logic [bad_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = bad_pkg::CFG_IDX_W'(2);
    localparam logic [bad_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic apogee;
        logic sampled;
    } apogee_flags_t;

    typedef enum int {ASCENT, COAST, DESCENT} trend_t;

    // Tracks the sample timer and the pressure window and holds the flags
    // expected for every accepted input transaction, oldest first.
    class apogee_scoreboard;
        logic [bad_pkg::INTERVAL_W-1:0] interval_ms;
        logic [bad_pkg::MARGIN_W-1:0]   margin;
        logic [bad_pkg::TIME_W-1:0]     last_time;
        logic [bad_pkg::PRESS_W-1:0]    window [bad_pkg::HISTORY_DEPTH];
        logic [bad_pkg::PTR_W-1:0]      ptr;
        bit                             full;
        apogee_flags_t                  flags_q[$];
        int                             errors;

        function new();
            interval_ms = bad_pkg::INTERVAL_RESET;
            margin      = bad_pkg::MARGIN_RESET;
            last_time   = '0;
            ptr         = '0;
            full        = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(input logic [bad_pkg::CFG_IDX_W-1:0]  idx,
                                input logic [bad_pkg::CFG_DATA_W-1:0] data);
            if (idx == bad_pkg::REG_SAMPLE_INTERVAL)
                interval_ms = data[bad_pkg::INTERVAL_W-1:0];
            else if (idx == bad_pkg::REG_RISE_MARGIN)
                margin = data[bad_pkg::MARGIN_W-1:0];
        endfunction

        function void note_input(input logic [bad_pkg::TIME_W-1:0]  t,
                                 input logic [bad_pkg::PRESS_W-1:0] p);
            apogee_flags_t               f;
            logic [bad_pkg::TIME_W-1:0]  elapsed;
            logic [bad_pkg::SUM_W-1:0]   limit;
            f       = '0;
            elapsed = t - last_time;
            if (elapsed >= bad_pkg::TIME_W'(interval_ms))
            begin
                f.sampled = 1'b1;
                last_time = t;
                limit     = bad_pkg::SUM_W'(window[ptr]) + bad_pkg::SUM_W'(margin);
                // Once the ring is full, a rise above the window-old value
                // plus the margin flags apogee and leaves the ring alone.
                if (full && bad_pkg::SUM_W'(p) > limit)
                begin
                    f.apogee = 1'b1;
                end
                else
                begin
                    window[ptr] = p;
                    if (ptr == bad_pkg::LAST_PTR)
                    begin
                        ptr  = '0;
                        full = 1'b1;
                    end
                    else
                    begin
                        ptr = ptr + 1'b1;
                    end
                end
            end
            flags_q.push_back(f);
        endfunction

        function void check_result(input logic a, input logic s);
            apogee_flags_t want;
            if (flags_q.size() == 0)
            begin
                $error("result with no pending transaction: apogee %0b, sampled %0b", a, s);
                errors++;
            end
            else
            begin
                want = flags_q.pop_front();
                if (a !== want.apogee)
                begin
                    $error("apogee: expected %0b, got %0b", want.apogee, a);
                    errors++;
                end
                if (s !== want.sampled)
                begin
                    $error("sampled: expected %0b, got %0b", want.sampled, s);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return flags_q.size();
        endfunction

        function logic [bad_pkg::PRESS_W-1:0] window_value();
            return window[ptr];
        endfunction
    endclass

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    logic [bad_pkg::TIME_W-1:0]        time_ms   = '0;
    logic [bad_pkg::PRESS_W-1:0]       pressure  = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              apogee;
    logic                              sampled;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [bad_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [bad_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    apogee_scoreboard               sb = new();
    bit                             gap_en    = 1'b0;
    bit                             stall_en  = 1'b0;
    int                             stall_cnt = 0;
    int                             quiet_cycles = 0;
    logic [bad_pkg::TIME_W-1:0]     now_ms    = '0;
    logic [bad_pkg::PRESS_W-1:0]    cur_p     = bad_pkg::PRESS_W'(101325);
    trend_t                         trend     = ASCENT;
    int                             ph;
    int                             n;
    logic [bad_pkg::INTERVAL_W-1:0] iv;
    logic [bad_pkg::MARGIN_W-1:0]   mg;

    barometric_apogee_detector i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .time_ms   (time_ms),
        .pressure  (pressure),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .apogee    (apogee),
        .sampled   (sampled),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Output side holds off in random bursts while enabled.
    always @(posedge clk)
    begin
        if (stall_cnt > 0)
            stall_cnt--;
        else if (stall_en && $urandom_range(0, 7) == 0)
            stall_cnt = $urandom_range(1, 16);
        out_stall <= (stall_cnt > 0);
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(apogee, sampled);
    end

    // The run ends if no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [bad_pkg::PRESS_W-1:0] clip_pressure(input int v);
        if (v < 0)
            return '0;
        if (v > PRESS_MAX)
            return bad_pkg::PRESS_W'(PRESS_MAX);
        return bad_pkg::PRESS_W'(v);
    endfunction

    // Offers one sensor transaction, after an optional gap, and records it
    // with the scoreboard at the edge where it is taken.
    task automatic send_item(input logic [bad_pkg::TIME_W-1:0]  t,
                             input logic [bad_pkg::PRESS_W-1:0] p);
        int gap;
        gap = 0;
        if (gap_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_ms  <= t;
        pressure <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        now_ms = t;
        sb.note_input(t, p);
    endtask

    task automatic send_after(input logic [bad_pkg::TIME_W-1:0]  delta,
                              input logic [bad_pkg::PRESS_W-1:0] p);
        send_item(now_ms + delta, p);
    endtask

    // Sends a sample placed relative to the apogee threshold of the
    // window-old entry.
    task automatic probe(input int offset);
        int v;
        v = int'(sb.window_value()) + int'(sb.margin) + offset;
        send_after(bad_pkg::TIME_W'(sb.interval_ms), clip_pressure(v));
    endtask

    task automatic write_reg(input logic [bad_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [bad_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [bad_pkg::CFG_DATA_W-1:0] interval_data,
                             input logic [bad_pkg::MARGIN_W-1:0]   margin);
        write_reg(bad_pkg::REG_SAMPLE_INTERVAL, interval_data);
        write_reg(bad_pkg::REG_RISE_MARGIN, bad_pkg::CFG_DATA_W'(margin));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Mostly a flight profile on the sample grid, plus early timestamps,
    // arbitrary noise and samples right at the apogee threshold.
    task automatic send_random_item();
        int                          kind;
        int                          step;
        logic [bad_pkg::TIME_W-1:0]  ivl;
        ivl  = bad_pkg::TIME_W'(sb.interval_ms);
        kind = $urandom_range(0, 99);
        if (kind < 68)
        begin
            case (trend)
                ASCENT:  step = int'($urandom_range(0, 45)) - 40;
                COAST:   step = int'($urandom_range(0, 6)) - 3;
                default: step = int'($urandom_range(0, 45)) - 5;
            endcase
            cur_p = clip_pressure(int'(cur_p) + step);
            send_after(ivl + $urandom_range(0, ivl / 4 + 2), cur_p);
        end
        else if (kind < 84)
        begin
            send_after((ivl == 0) ? '0 : $urandom_range(0, ivl - 1),
                       bad_pkg::PRESS_W'($urandom));
        end
        else if (kind < 92)
        begin
            send_item($urandom, bad_pkg::PRESS_W'($urandom));
        end
        else
        begin
            probe(int'($urandom_range(0, 2)) - 1);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n    <= 1'b1;
        gap_en   = 1'b1;
        stall_en = 1'b1;

        // Sample timer with reset settings: first edge of the interval,
        // a jump far ahead, and a difference that wraps through zero.
        send_item(32'd0, '0);
        send_item(32'd9, '0);
        send_item(32'd10, bad_pkg::PRESS_W'(PRESS_MAX));
        send_item(32'd19, '0);
        send_item(32'd20, bad_pkg::PRESS_W'(PRESS_MAX));
        send_item(32'hFFFF_FFFF, bad_pkg::PRESS_W'(PRESS_MAX));
        send_item(32'd4, '0);
        send_item(32'd9, bad_pkg::PRESS_W'(PRESS_MAX));

        // Fill the rest of the ring; the next few entries hold zero.
        while (!sb.full)
            send_after(32'd10, (sb.ptr < 10) ? '0 : bad_pkg::PRESS_W'($urandom));

        // Full-scale window entries must not overflow the threshold.
        send_after(32'd10, bad_pkg::PRESS_W'(PRESS_MAX));
        send_after(32'd10, bad_pkg::PRESS_W'(PRESS_MAX));
        send_after(32'd10, '0);
        send_after(32'd10, '0);
        // Equal to the threshold, just above it twice, then back below.
        send_after(32'd10, bad_pkg::PRESS_W'(10));
        send_after(32'd10, bad_pkg::PRESS_W'(11));
        send_after(32'd10, bad_pkg::PRESS_W'(11));
        send_after(32'd10, bad_pkg::PRESS_W'(9));
        send_after(32'd9, bad_pkg::PRESS_W'(PRESS_MAX));
        send_after(32'd10, '0);
        in_valid <= 1'b0;

        // Largest margin against a zero window entry.
        wait_idle();
        configure(16'd10, '1);
        send_after(32'd10, bad_pkg::PRESS_W'(65535));
        send_after(32'd10, bad_pkg::PRESS_W'(65536));
        send_after(32'd10, '0);
        in_valid <= 1'b0;

        // Zero margin.
        wait_idle();
        configure(16'd10, '0);
        send_after(32'd10, '0);
        probe(1);
        probe(0);
        in_valid <= 1'b0;

        // Longest interval that this bench uses.
        wait_idle();
        configure(16'd1000, bad_pkg::MARGIN_W'(10));
        send_after(32'd999, bad_pkg::PRESS_W'(PRESS_MAX));
        send_after(32'd1000, bad_pkg::PRESS_W'(PRESS_MAX));
        in_valid <= 1'b0;

        // Zero interval samples every transaction; upper data bits are dropped.
        wait_idle();
        configure(16'hFC00, bad_pkg::MARGIN_W'(10));
        send_after(32'd0, bad_pkg::PRESS_W'(PRESS_MAX));
        in_valid <= 1'b0;

        // Shortest nonzero interval, with writes to unused indexes in between.
        wait_idle();
        write_reg(bad_pkg::REG_SAMPLE_INTERVAL, 16'd1);
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, 16'd1);
        cfg_valid <= 1'b0;
        send_after(32'd0, '0);
        send_after(32'd1, '0);
        in_valid <= 1'b0;

        // Random phases, each with its own settings and idling mode.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    iv = bad_pkg::INTERVAL_W'(10);
                    mg = bad_pkg::MARGIN_W'(10);
                end
                1:
                begin
                    iv = bad_pkg::INTERVAL_W'(1);
                    mg = '0;
                end
                2:
                begin
                    iv = bad_pkg::INTERVAL_W'(1000);
                    mg = '1;
                end
                3:
                begin
                    iv = bad_pkg::INTERVAL_W'($urandom_range(1, 1000));
                    mg = bad_pkg::MARGIN_W'($urandom);
                end
                4:
                begin
                    iv = bad_pkg::INTERVAL_W'($urandom_range(1, 50));
                    mg = bad_pkg::MARGIN_W'(1);
                end
                5:
                begin
                    iv = '0;
                    mg = bad_pkg::MARGIN_W'($urandom_range(0, 200));
                end
                6:
                begin
                    iv = bad_pkg::INTERVAL_W'(10);
                    mg = bad_pkg::MARGIN_W'(10);
                end
                7:
                begin
                    iv = bad_pkg::INTERVAL_W'($urandom_range(1, 200));
                    mg = bad_pkg::MARGIN_W'($urandom_range(0, 2000));
                end
                default:
                begin
                    iv = bad_pkg::INTERVAL_W'(10);
                    mg = bad_pkg::MARGIN_W'($urandom_range(0, 50));
                end
            endcase
            configure({6'($urandom), iv}, mg);
            if (ph == RANDOM_PHASES - 1)
                n = 0;
            else
                n = $urandom_range(0, 3);
            gap_en   = n[0];
            stall_en = n[1];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    trend = trend_t'($urandom_range(0, 2));
                send_random_item();
            end
            in_valid <= 1'b0;
        end

        stall_en = 1'b0;
        wait_idle();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hdl/bad_pkg.sv
hdl/bad_history.sv
hdl/barometric_apogee_detector.sv
hdl/bad_checker.sv
tb/tb_barometric_apogee_detector.sv
